>>> rtl/eaoc_pkg.sv
// Shared types, constants and arithmetic helpers for the Euler angle order converter.
`default_nettype none
package eaoc_pkg;

    localparam int WordWidth  = 34;
    localparam int RadWidth   = 63;
    localparam int StepWidth  = 5;
    localparam int CordicLen  = 16;
    localparam int SqrtLen    = 32;
    localparam int Latency    = 72;
    localparam int InShift    = 17;

    typedef logic signed [WordWidth-1:0] word_t;
    typedef logic [RadWidth-1:0]         rad_t;
    typedef logic [StepWidth-1:0]        step_t;

    localparam word_t OneQ    = word_t'(64'sd1073741824);
    localparam word_t PiQ     = word_t'(64'sd3373259426);
    localparam word_t HalfPiQ = word_t'(64'sd1686629713);
    localparam word_t KGainQ  = word_t'(64'sd652032874);
    localparam word_t LockEps = word_t'(64'sd1073);

    typedef struct packed {
        logic       mode;
        logic [2:0] neg;
    } cor_sb_t;

    typedef struct packed {
        word_t s;
        word_t d;
        word_t e;
        word_t g;
        word_t h;
        word_t b;
        word_t r11;
    } mat_t;

    typedef struct packed {
        word_t x;
        word_t y;
        word_t z;
    } vec_t;

    function automatic word_t atan_q(input step_t i);
        word_t r;
        case (i)
            5'd0:    r = word_t'(34'h3243F6A8);
            5'd1:    r = word_t'(34'h1DAC6705);
            5'd2:    r = word_t'(34'h0FADBAFC);
            5'd3:    r = word_t'(34'h07F56EA6);
            5'd4:    r = word_t'(34'h03FEAB76);
            5'd5:    r = word_t'(34'h01FFD55B);
            5'd6:    r = word_t'(34'h00FFFAAA);
            5'd7:    r = word_t'(34'h007FFF55);
            5'd8:    r = word_t'(34'h003FFFEA);
            5'd9:    r = word_t'(34'h001FFFFD);
            5'd10:   r = word_t'(34'h000FFFFF);
            5'd11:   r = word_t'(34'h0007FFFF);
            5'd12:   r = word_t'(34'h0003FFFF);
            5'd13:   r = word_t'(34'h0001FFFF);
            5'd14:   r = word_t'(34'h0000FFFF);
            5'd15:   r = word_t'(34'h00007FFF);
            5'd16:   r = word_t'(34'h00003FFF);
            5'd17:   r = word_t'(34'h00001FFF);
            5'd18:   r = word_t'(34'h00000FFF);
            5'd19:   r = word_t'(34'h000007FF);
            5'd20:   r = word_t'(34'h000003FF);
            5'd21:   r = word_t'(34'h000001FF);
            5'd22:   r = word_t'(34'h000000FF);
            5'd23:   r = word_t'(34'h0000007F);
            5'd24:   r = word_t'(34'h0000003F);
            5'd25:   r = word_t'(34'h0000001F);
            5'd26:   r = word_t'(34'h0000000F);
            5'd27:   r = word_t'(34'h00000007);
            5'd28:   r = word_t'(34'h00000003);
            5'd29:   r = word_t'(34'h00000001);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic word_t mulq(input word_t a, input word_t b);
        logic signed [2*WordWidth-1:0] p;
        p = a * b;
        return p[WordWidth+29:30];
    endfunction

    function automatic word_t clampq(input logic signed [WordWidth:0] v);
        word_t r;
        if (v > (WordWidth+1)'(OneQ)) begin
            r = OneQ;
        end else if (v < -(WordWidth+1)'(OneQ)) begin
            r = -OneQ;
        end else begin
            r = v[WordWidth-1:0];
        end
        return r;
    endfunction

    function automatic vec_t vprep(input word_t y, input word_t x);
        vec_t r;
        if (x < 0) begin
            r.x = -x;
            r.y = -y;
            r.z = (y >= 0) ? PiQ : -PiQ;
        end else begin
            r.x = x;
            r.y = y;
            r.z = '0;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] angle_out(input word_t v);
        logic signed [WordWidth:0]        t;
        logic signed [WordWidth-InShift:0] q;
        logic signed [15:0]               r;
        t = (WordWidth+1)'(v) + (WordWidth+1)'(35'sd65536);
        q = t[WordWidth:InShift];
        if (q > 18'sd32767) begin
            r = 16'sh7FFF;
        end else if (q < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = q[15:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/eaoc_cordic_cell.sv
// One CORDIC micro-rotation cell, used in rotation or vectoring mode.
`default_nettype none
module eaoc_cordic_cell (
    input  wire                     clk,
    input  wire eaoc_pkg::step_t    step,
    input  wire                     vec_mode,
    input  wire eaoc_pkg::word_t    src_x,
    input  wire eaoc_pkg::word_t    src_y,
    input  wire eaoc_pkg::word_t    src_z,
    output eaoc_pkg::word_t         dst_x,
    output eaoc_pkg::word_t         dst_y,
    output eaoc_pkg::word_t         dst_z
);
    import eaoc_pkg::*;

    word_t x_reg, y_reg, z_reg;
    word_t x_next, y_next, z_next;
    word_t xs, ys, at;
    logic  plus;
    logic  hold;

    always_comb
    begin
        xs   = src_x >>> step;
        ys   = src_y >>> step;
        at   = atan_q(step);
        plus = vec_mode ? (src_y < 0) : (src_z >= 0);
        hold = vec_mode && (src_y == 0);
        if (hold)
        begin
            x_next = src_x;
            y_next = src_y;
            z_next = src_z;
        end
        else if (plus)
        begin
            x_next = src_x - ys;
            y_next = src_y + xs;
            z_next = src_z - at;
        end
        else
        begin
            x_next = src_x + ys;
            y_next = src_y - xs;
            z_next = src_z + at;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign dst_x = x_reg;
    assign dst_y = y_reg;
    assign dst_z = z_reg;
endmodule
`default_nettype wire

>>> rtl/eaoc_sqrt_cell.sv
// One step of the digit-by-digit integer square root.
`default_nettype none
module eaoc_sqrt_cell (
    input  wire                   clk,
    input  wire eaoc_pkg::step_t  step,
    input  wire eaoc_pkg::rad_t   src_rem,
    input  wire eaoc_pkg::rad_t   src_root,
    output eaoc_pkg::rad_t        dst_rem,
    output eaoc_pkg::rad_t        dst_root
);
    import eaoc_pkg::*;

    rad_t rem_reg, root_reg;
    rad_t rem_next, root_next;
    rad_t bitv, trial;

    always_comb
    begin
        bitv  = rad_t'(1) << (6'd62 - {step, 1'b0});
        trial = src_root + bitv;
        if (src_rem >= trial)
        begin
            rem_next  = src_rem - trial;
            root_next = (src_root >> 1) + bitv;
        end
        else
        begin
            rem_next  = src_rem;
            root_next = src_root >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign dst_rem  = rem_reg;
    assign dst_root = root_reg;
endmodule
`default_nettype wire

>>> rtl/euler_angle_order_converter_core.sv
// Top level of the Euler angle order converter: a fully pipelined datapath.
// Usage: drive mode and angle_x/y/z with start high; busy is always low, so
// a transfer takes place at every rising edge at which start is high, and a
// new item may follow in every cycle.
// Each item yields one result, shown on out_x, out_y, out_z and gimbal_lock
// for a single cycle while done is high.
// Throughput is one item per clock. The pipeline holds, in order: input
// reduction, sixteen sine/cosine CORDIC cells, the sign correction, two
// multiplier stages, the matrix combine, the squaring stage, thirty-two
// square-root cells, the branch selection, sixteen atan2 CORDIC cells and
// the output rounding.
// Results leave in transfer order. The receiver cannot stall the block,
// so done must be sampled whenever it is high.
// Reset clears only the valid line; the datapath holds no state that
// outlives an item, and done stays low until the first result arrives.
// Mode 0 converts roll-pitch-yaw to yaw-pitch-roll, mode 1 the reverse.
`default_nettype none
module euler_angle_order_converter_core (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               start,
    output logic              busy,
    input  wire               mode,
    input  wire signed [15:0] angle_x,
    input  wire signed [15:0] angle_y,
    input  wire signed [15:0] angle_z,
    output logic              done,
    output logic signed [15:0] out_x,
    output logic signed [15:0] out_y,
    output logic signed [15:0] out_z,
    output logic              gimbal_lock
);
    import eaoc_pkg::*;

    logic [Latency-1:0] valid_reg, valid_next;
    logic               accept;

    word_t   cor_x [0:CordicLen][0:2];
    word_t   cor_y [0:CordicLen][0:2];
    word_t   cor_z [0:CordicLen][0:2];
    cor_sb_t cor_sb_reg [0:CordicLen];

    word_t   ang [0:2];
    word_t   red [0:2];
    logic [2:0] neg;

    word_t sx_reg, cx_reg, sy_reg, cy_reg, sz_reg, cz_reg;
    word_t sx_reg_d1, cx_reg_d1, sz_reg_d1, cz_reg_d1;
    logic  mode_sc_reg, mode_m1_reg, mode_m2_reg;
    word_t u_reg, v_reg;
    word_t cycz_reg, cysz_reg, cxcy_reg, cxsz_reg, sxsz_reg, cxcz_reg, sxcz_reg;
    word_t cycz2_reg, cysz2_reg, cxcy2_reg, cxsz2_reg, sxsz2_reg, cxcz2_reg, sxcz2_reg;
    word_t p1_reg, p2_reg, p3_reg, p4_reg;
    mat_t  mat_reg, mat_next;

    rad_t  sq_rem [0:SqrtLen];
    rad_t  sq_root [0:SqrtLen];
    mat_t  sq_sb_reg [0:SqrtLen];

    word_t at_x [0:CordicLen][0:2];
    word_t at_y [0:CordicLen][0:2];
    word_t at_z [0:CordicLen][0:2];
    logic  at_lock_reg [0:CordicLen];
    word_t root_c;
    logic  lock;
    vec_t  vp [0:2];

    logic signed [15:0] out_x_reg, out_y_reg, out_z_reg;
    logic               lock_out_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        valid_next = {valid_reg[Latency-2:0], accept};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Input scaling to Q.30 and reduction into [-pi/2, pi/2].
    always_comb
    begin
        ang[0] = word_t'(angle_x) <<< InShift;
        ang[1] = word_t'(angle_y) <<< InShift;
        ang[2] = word_t'(angle_z) <<< InShift;
        for (int j = 0; j < 3; j++)
        begin
            if (ang[j] > HalfPiQ)
            begin
                red[j] = ang[j] - PiQ;
                neg[j] = 1'b1;
            end
            else if (ang[j] < -HalfPiQ)
            begin
                red[j] = ang[j] + PiQ;
                neg[j] = 1'b1;
            end
            else
            begin
                red[j] = ang[j];
                neg[j] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            cor_x[0][j] <= KGainQ;
            cor_y[0][j] <= '0;
            cor_z[0][j] <= red[j];
        end
        cor_sb_reg[0] <= '{mode: mode, neg: neg};
    end

    for (genvar k = 0; k < CordicLen; k++)
    begin : g_sincos
        for (genvar j = 0; j < 3; j++)
        begin : g_lane
            eaoc_cordic_cell u_cell (
                .clk      (clk),
                .step     (step_t'(k)),
                .vec_mode (1'b0),
                .src_x    (cor_x[k][j]),
                .src_y    (cor_y[k][j]),
                .src_z    (cor_z[k][j]),
                .dst_x    (cor_x[k+1][j]),
                .dst_y    (cor_y[k+1][j]),
                .dst_z    (cor_z[k+1][j])
            );
        end
        always_ff @(posedge clk)
        begin
            cor_sb_reg[k+1] <= cor_sb_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        sx_reg <= cor_sb_reg[CordicLen].neg[0] ? -cor_y[CordicLen][0] : cor_y[CordicLen][0];
        cx_reg <= cor_sb_reg[CordicLen].neg[0] ? -cor_x[CordicLen][0] : cor_x[CordicLen][0];
        sy_reg <= cor_sb_reg[CordicLen].neg[1] ? -cor_y[CordicLen][1] : cor_y[CordicLen][1];
        cy_reg <= cor_sb_reg[CordicLen].neg[1] ? -cor_x[CordicLen][1] : cor_x[CordicLen][1];
        sz_reg <= cor_sb_reg[CordicLen].neg[2] ? -cor_y[CordicLen][2] : cor_y[CordicLen][2];
        cz_reg <= cor_sb_reg[CordicLen].neg[2] ? -cor_x[CordicLen][2] : cor_x[CordicLen][2];
        mode_sc_reg <= cor_sb_reg[CordicLen].mode;
    end

    // First products.
    always_ff @(posedge clk)
    begin
        u_reg       <= mode_sc_reg ? mulq(cz_reg, sy_reg) : mulq(sx_reg, sy_reg);
        v_reg       <= mode_sc_reg ? mulq(sz_reg, sy_reg) : mulq(cx_reg, sy_reg);
        cycz_reg    <= mulq(cy_reg, cz_reg);
        cysz_reg    <= mulq(cy_reg, sz_reg);
        cxcy_reg    <= mulq(cx_reg, cy_reg);
        cxsz_reg    <= mulq(cx_reg, sz_reg);
        sxsz_reg    <= mulq(sx_reg, sz_reg);
        cxcz_reg    <= mulq(cx_reg, cz_reg);
        sxcz_reg    <= mulq(sx_reg, cz_reg);
        mode_m1_reg <= mode_sc_reg;
    end

    always_ff @(posedge clk)
    begin
        sx_reg_d1 <= sx_reg;
        cx_reg_d1 <= cx_reg;
        sz_reg_d1 <= sz_reg;
        cz_reg_d1 <= cz_reg;
    end

    // Second products, on the triple terms.
    always_ff @(posedge clk)
    begin
        p1_reg      <= mulq(u_reg, mode_m1_reg ? sx_reg_d1 : cz_reg_d1);
        p2_reg      <= mulq(u_reg, mode_m1_reg ? cx_reg_d1 : sz_reg_d1);
        p3_reg      <= mulq(v_reg, mode_m1_reg ? sx_reg_d1 : cz_reg_d1);
        p4_reg      <= mulq(v_reg, mode_m1_reg ? cx_reg_d1 : sz_reg_d1);
        cycz2_reg   <= cycz_reg;
        cysz2_reg   <= cysz_reg;
        cxcy2_reg   <= cxcy_reg;
        cxsz2_reg   <= cxsz_reg;
        sxsz2_reg   <= sxsz_reg;
        cxcz2_reg   <= cxcz_reg;
        sxcz2_reg   <= sxcz_reg;
        mode_m2_reg <= mode_m1_reg;
    end

    // Matrix entries, clamped, and the numerators of each output angle.
    always_comb
    begin
        word_t r00, r01, r10, r11, r22, a, e1;
        r00 = clampq((WordWidth+1)'(cycz2_reg));
        r22 = clampq((WordWidth+1)'(cxcy2_reg));
        if (!mode_m2_reg)
        begin
            r01 = clampq((WordWidth+1)'(p1_reg) - (WordWidth+1)'(cxsz2_reg));
            r10 = clampq((WordWidth+1)'(cysz2_reg));
            r11 = clampq((WordWidth+1)'(p2_reg) + (WordWidth+1)'(cxcz2_reg));
            a   = clampq((WordWidth+1)'(p4_reg) - (WordWidth+1)'(sxcz2_reg));
            e1  = '0;
            mat_next.s   = clampq((WordWidth+1)'(p3_reg) + (WordWidth+1)'(sxsz2_reg));
            mat_next.d   = -a;
            mat_next.g   = -r01;
            mat_next.b   = r10;
        end
        else
        begin
            r01 = clampq(-(WordWidth+1)'(cysz2_reg));
            r10 = clampq((WordWidth+1)'(p1_reg) + (WordWidth+1)'(cxsz2_reg));
            r11 = clampq((WordWidth+1)'(cxcz2_reg) - (WordWidth+1)'(p3_reg));
            a   = clampq((WordWidth+1)'(sxsz2_reg) - (WordWidth+1)'(p2_reg));
            e1  = clampq((WordWidth+1)'(p4_reg) + (WordWidth+1)'(sxcz2_reg));
            mat_next.s   = -a;
            mat_next.d   = e1;
            mat_next.g   = r10;
            mat_next.b   = -r01;
        end
        mat_next.e   = r22;
        mat_next.h   = r00;
        mat_next.r11 = r11;
    end

    always_ff @(posedge clk)
    begin
        mat_reg <= mat_next;
    end

    // Radicand 2^60 - s*s for the middle cosine.
    always_ff @(posedge clk)
    begin
        logic signed [2*WordWidth-1:0] ss;
        ss = mat_reg.s * mat_reg.s;
        sq_rem[0]    <= (rad_t'(1) << 60) - rad_t'(ss[RadWidth-1:0]);
        sq_root[0]   <= '0;
        sq_sb_reg[0] <= mat_reg;
    end

    for (genvar k = 0; k < SqrtLen; k++)
    begin : g_sqrt
        eaoc_sqrt_cell u_cell (
            .clk      (clk),
            .step     (step_t'(k)),
            .src_rem  (sq_rem[k]),
            .src_root (sq_root[k]),
            .dst_rem  (sq_rem[k+1]),
            .dst_root (sq_root[k+1])
        );
        always_ff @(posedge clk)
        begin
            sq_sb_reg[k+1] <= sq_sb_reg[k];
        end
    end

    // Branch selection on gimbal lock and atan2 pre-rotation.
    always_comb
    begin
        root_c = word_t'(sq_root[SqrtLen][WordWidth-1:0]);
        lock   = (root_c <= LockEps);
        vp[0]  = vprep(sq_sb_reg[SqrtLen].d, sq_sb_reg[SqrtLen].e);
        vp[1]  = vprep(sq_sb_reg[SqrtLen].s, root_c);
        vp[2]  = lock ? vprep(sq_sb_reg[SqrtLen].b, sq_sb_reg[SqrtLen].r11)
                      : vprep(sq_sb_reg[SqrtLen].g, sq_sb_reg[SqrtLen].h);
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            at_x[0][j] <= vp[j].x;
            at_y[0][j] <= vp[j].y;
            at_z[0][j] <= vp[j].z;
        end
        at_lock_reg[0] <= lock;
    end

    for (genvar k = 0; k < CordicLen; k++)
    begin : g_atan
        for (genvar j = 0; j < 3; j++)
        begin : g_lane
            eaoc_cordic_cell u_cell (
                .clk      (clk),
                .step     (step_t'(k)),
                .vec_mode (1'b1),
                .src_x    (at_x[k][j]),
                .src_y    (at_y[k][j]),
                .src_z    (at_z[k][j]),
                .dst_x    (at_x[k+1][j]),
                .dst_y    (at_y[k+1][j]),
                .dst_z    (at_z[k+1][j])
            );
        end
        always_ff @(posedge clk)
        begin
            at_lock_reg[k+1] <= at_lock_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        out_x_reg    <= at_lock_reg[CordicLen] ? 16'sd0 : angle_out(at_z[CordicLen][0]);
        out_y_reg    <= angle_out(at_z[CordicLen][1]);
        out_z_reg    <= angle_out(at_z[CordicLen][2]);
        lock_out_reg <= at_lock_reg[CordicLen];
    end

    assign done        = valid_reg[Latency-1];
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign out_z       = out_z_reg;
    assign gimbal_lock = lock_out_reg;

    a_lock_zero_x: assert property (@(posedge clk) disable iff (!rst_n)
        done && gimbal_lock |-> out_x == 16'sd0)
        else $error("Locked result carries a non-zero first angle.");

    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, Latency))
        else $error("Result strobe without a matching transfer.");

    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##Latency done)
        else $error("Transfer produced no result.");

endmodule
`default_nettype wire

>>> tb/euler_angle_order_converter_core_test.sv
// Self-checking testbench for the Euler angle order converter core.
`default_nettype none
module euler_angle_order_converter_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint OneQ    = 64'sd1073741824;
    localparam longint PiQ     = 64'sd3373259426;
    localparam longint HalfPiQ = 64'sd1686629713;
    localparam longint KGain   = 64'sd652032874;
    localparam longint LockEps = 64'sd1073;
    localparam int     Stages  = 16;
    localparam int     Delay   = 72;
    localparam longint CycleLimit = 400000;
    localparam logic   ModeRpyToYpr = 1'b0;
    localparam logic   ModeYprToRpy = 1'b1;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               lock;
    } pose_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic mode;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic done;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic gimbal_lock;

    pose_t  pending_poses[$];
    int     error_count = 0;
    longint cycle_count = 0;

    euler_angle_order_converter_core u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z), .done(done),
        .out_x(out_x), .out_y(out_y), .out_z(out_z), .gimbal_lock(gimbal_lock)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint tab_atan(input int i);
        longint t[30] = '{
            64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
            64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
            64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
            64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
            64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
            64'h0000001F, 64'h0000000F, 64'h00000007, 64'h00000003, 64'h00000001};
        return (i < 30) ? t[i] : 64'sd0;
    endfunction

    function automatic longint fmul(input longint a, input longint b);
        return (a * b) >>> 30;
    endfunction

    function automatic longint clip(input longint v);
        if (v > OneQ) return OneQ;
        if (v < -OneQ) return -OneQ;
        return v;
    endfunction

    function automatic void sin_cos(input longint ang, output longint s, output longint c);
        longint x, y, z, nx;
        bit flip;
        x = KGain;
        y = 0;
        z = ang;
        flip = 0;
        if (z > HalfPiQ)
        begin
            z -= PiQ;
            flip = 1;
        end
        else if (z < -HalfPiQ)
        begin
            z += PiQ;
            flip = 1;
        end
        for (int i = 0; i < Stages; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= tab_atan(i);
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += tab_atan(i);
            end
            x = nx;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic longint arc_tan2(input longint yin, input longint xin);
        longint x, y, z, nx;
        x = xin;
        y = yin;
        z = 0;
        if (x < 0)
        begin
            z = (y >= 0) ? PiQ : -PiQ;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < Stages; i++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += tab_atan(i);
                x = nx;
            end
            else if (y < 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= tab_atan(i);
                x = nx;
            end
        end
        return z;
    endfunction

    function automatic longint root_floor(input longint n);
        longint r, b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > n) b >>>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >>> 1) + b;
            end
            else
                r >>>= 1;
            b >>>= 2;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] to_q13(input longint v);
        longint r;
        r = (v + (64'sd1 <<< 16)) >>> 17;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic pose_t convert_pose(input logic m, input logic signed [15:0] ax,
                                           input logic signed [15:0] ay,
                                           input logic signed [15:0] az);
        longint sx, cx, sy, cy, sz, cz;
        longint r00, r01, r10, r11, r22, s, a, b, d, e, g, h, c;
        pose_t p;
        sin_cos(longint'(ax) <<< 17, sx, cx);
        sin_cos(longint'(ay) <<< 17, sy, cy);
        sin_cos(longint'(az) <<< 17, sz, cz);
        if (m == ModeRpyToYpr)
        begin
            r00 = clip(fmul(cy, cz));
            r01 = clip(fmul(fmul(sx, sy), cz) - fmul(cx, sz));
            s   = clip(fmul(fmul(cx, sy), cz) + fmul(sx, sz));
            r10 = clip(fmul(cy, sz));
            r11 = clip(fmul(fmul(sx, sy), sz) + fmul(cx, cz));
            a   = clip(fmul(fmul(cx, sy), sz) - fmul(sx, cz));
            r22 = clip(fmul(cx, cy));
            d = -a;
            e = r22;
            g = -r01;
            h = r00;
            b = r10;
        end
        else
        begin
            r00 = clip(fmul(cz, cy));
            r01 = clip(-fmul(sz, cy));
            r10 = clip(fmul(fmul(cz, sy), sx) + fmul(sz, cx));
            r11 = clip(fmul(cz, cx) - fmul(fmul(sz, sy), sx));
            a   = clip(fmul(sz, sx) - fmul(fmul(cz, sy), cx));
            e   = clip(fmul(fmul(sz, sy), cx) + fmul(cz, sx));
            r22 = clip(fmul(cx, cy));
            s = -a;
            d = e;
            e = r22;
            g = r10;
            h = r00;
            b = -r01;
        end
        c = root_floor(OneQ * OneQ - s * s);
        p.y = to_q13(arc_tan2(s, c));
        p.lock = (c <= LockEps);
        if (!p.lock)
        begin
            p.x = to_q13(arc_tan2(d, e));
            p.z = to_q13(arc_tan2(g, h));
        end
        else
        begin
            p.x = '0;
            p.z = to_q13(arc_tan2(b, r11));
        end
        return p;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        pose_t w;
        cycle_count <= cycle_count + 1;
        if (rst_n && done)
        begin
            if (pending_poses.size() == 0)
                report_mismatch("unexpected result", 0, 0);
            else
            begin
                w = pending_poses.pop_front();
                if (out_x !== w.x) report_mismatch("out_x", out_x, w.x);
                if (out_y !== w.y) report_mismatch("out_y", out_y, w.y);
                if (out_z !== w.z) report_mismatch("out_z", out_z, w.z);
                if (gimbal_lock !== w.lock) report_mismatch("gimbal_lock", gimbal_lock, w.lock);
            end
        end
    end

    int burst_left;

    task automatic send_pose(input logic m, input logic signed [15:0] ax,
                             input logic signed [15:0] ay, input logic signed [15:0] az,
                             input bit paced);
        if (paced)
        begin
            if (burst_left == 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 10);
            end
            burst_left--;
        end
        mode <= m;
        angle_x <= ax;
        angle_y <= ay;
        angle_z <= az;
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        pending_poses = {pending_poses, convert_pose(m, ax, ay, az)};
        @(negedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_poses.size() != 0) @(negedge clk);
    endtask

    task automatic test_extremes();
        logic signed [15:0] v[7] = '{16'sh8000, 16'sh7FFF, 16'sd0, 16'sd12868,
                                     -16'sd12868, 16'sd25736, -16'sd25736};
        for (int m = 0; m < 2; m++)
            for (int i = 0; i < 7; i++)
                send_pose(m[0], v[i], v[(i + 3) % 7], v[(i + 5) % 7], 1'b0);
    endtask

    task automatic test_gimbal_lock();
        send_pose(ModeRpyToYpr, 16'sd1000, 16'sd12868, -16'sd700, 1'b0);
        send_pose(ModeRpyToYpr, -16'sd3000, -16'sd12868, 16'sd2000, 1'b0);
        send_pose(ModeYprToRpy, 16'sd1500, 16'sd12868, 16'sd400, 1'b0);
        send_pose(ModeYprToRpy, 16'sd0, -16'sd12868, -16'sd5000, 1'b0);
        send_pose(ModeRpyToYpr, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        send_pose(ModeYprToRpy, 16'sd25736, 16'sd0, 16'sd0, 1'b0);
    endtask

    task automatic test_random(input int count);
        logic signed [15:0] ay;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(0, 3))
                0: ay = $urandom_range(0, 1) ? 16'sd12868 : -16'sd12868;
                1: ay = 16'(int'($urandom_range(0, 12867)) * ($urandom_range(0, 1) ? 1 : -1));
                default: ay = 16'($urandom);
            endcase
            send_pose(1'($urandom_range(0, 1)), 16'($urandom), ay, 16'($urandom), 1'b1);
        end
    endtask

    task automatic test_back_to_back();
        for (int n = 0; n < 150; n++)
            send_pose(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                      16'($urandom), 1'b0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        mode = 1'b0;
        angle_x = '0;
        angle_y = '0;
        angle_z = '0;
        burst_left = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_extremes();
        test_gimbal_lock();
        test_random(500);
        wait_drained();
        test_back_to_back();
        test_random(480);
        wait_drained();
        repeat (Delay + 10) @(negedge clk);
        if (error_count == 0)
            $display("[euler_angle_order_converter_core] OK");
        else
            $display("[euler_angle_order_converter_core] ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (cycle_count > CycleLimit)
        begin
            $display("[euler_angle_order_converter_core] ERROR");
            $finish;
        end
    end
endmodule
`default_nettype wire

>>> filelist.f
rtl/eaoc_pkg.sv
rtl/eaoc_cordic_cell.sv
rtl/eaoc_sqrt_cell.sv
rtl/euler_angle_order_converter_core.sv
tb/euler_angle_order_converter_core_test.sv
